### rtl/fvsv_pkg.sv
// Shared widths, types and constants for the vortex segment velocity pipeline.
package fvsv_pkg;

    // Input coordinate and first difference widths.
    localparam int COORD_W  = 32;
    localparam int DIFF_W   = 33;
    localparam int PROD_W   = 66;

    // Cross product components (signed) and their magnitudes.
    localparam int CROSS_W  = 68;
    localparam int MAG_W    = 67;

    // Squared lengths (unsigned) and the signed dot products l.r.
    localparam int SQ_W     = 66;
    localparam int DOT_W    = 69;

    // Square root of a squared length scaled by 2^64.
    localparam int ROOT_W   = 65;

    // Division for u = l.r * 2^64 / |r|.
    localparam int UD_STEPS = 67;
    localparam int UD_NUM_W = 134;
    localparam int UD_REM_W = 67;
    localparam int UD_DIV_W = 66;
    localparam int UNIT_W   = 68;
    localparam int DIFFU_W  = 69;

    // Wide multiplier and the final velocity division.
    localparam int MUL_W    = 68;
    localparam int MUL_H    = 34;
    localparam int MULP_W   = 136;
    localparam int VD_STEPS = 32;
    localparam int VD_NUM_W = 137;

    // Delay line lengths that keep side data aligned with the long units.
    localparam int LR_DLY   = 65;
    localparam int D_DLY    = 136;
    localparam int ST_DLY   = 174;

    // Saturation limits of a Q16.16 output.
    localparam logic [COORD_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] VEL_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DEN_ZERO = 2'd1,
        ST_AT_START = 2'd2,
        ST_NEG_RAD  = 2'd3
    } status_t;

    // Everything the front end hands to the rest of the pipeline.
    typedef struct packed {
        logic [CROSS_W-1:0] dx;
        logic [CROSS_W-1:0] dy;
        logic [CROSS_W-1:0] dz;
        logic [SQ_W-1:0]    a;
        logic [SQ_W-1:0]    rr2;
        logic [DOT_W-1:0]   lr1;
        logic [DOT_W-1:0]   lr2;
        status_t            status;
    } front_t;

    // Sign and magnitude of one cross product component.
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
    } smag_t;

endpackage

### rtl/fvsv_front.sv
// Front end: differences, products and sums that give d, a, r2.r2 and l.r.
module fvsv_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [fvsv_pkg::COORD_W-1:0] start_x,
    input  logic signed [fvsv_pkg::COORD_W-1:0] start_y,
    input  logic signed [fvsv_pkg::COORD_W-1:0] start_z,
    input  logic signed [fvsv_pkg::COORD_W-1:0] end_x,
    input  logic signed [fvsv_pkg::COORD_W-1:0] end_y,
    input  logic signed [fvsv_pkg::COORD_W-1:0] end_z,
    input  logic signed [fvsv_pkg::COORD_W-1:0] target_x,
    input  logic signed [fvsv_pkg::COORD_W-1:0] target_y,
    input  logic signed [fvsv_pkg::COORD_W-1:0] target_z,
    output logic                            out_valid,
    output fvsv_pkg::front_t                out_data
);
    import fvsv_pkg::*;

    logic signed [COORD_W-1:0] s_c [3];
    logic signed [COORD_W-1:0] e_c [3];
    logic signed [COORD_W-1:0] t_c [3];

    logic signed [DIFF_W-1:0] r1_reg [3];
    logic signed [DIFF_W-1:0] r2_reg [3];
    logic signed [DIFF_W-1:0] l_reg  [3];

    logic signed [PROD_W-1:0] dp_reg  [6];
    logic signed [PROD_W-1:0] sq1_reg [3];
    logic signed [PROD_W-1:0] sq2_reg [3];
    logic signed [PROD_W-1:0] lp1_reg [3];
    logic signed [PROD_W-1:0] lp2_reg [3];

    logic   v1_reg, v2_reg, v3_reg;
    front_t out_next;
    front_t out_reg;

    // Gather the coordinates per axis.
    always_comb
    begin
        s_c[0] = start_x;  s_c[1] = start_y;  s_c[2] = start_z;
        e_c[0] = end_x;    e_c[1] = end_y;    e_c[2] = end_z;
        t_c[0] = target_x; t_c[1] = target_y; t_c[2] = target_z;
    end

    // Valid bits travel with the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage one: exact 33-bit differences.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            r1_reg[k] <= DIFF_W'(t_c[k]) - DIFF_W'(s_c[k]);
            r2_reg[k] <= DIFF_W'(t_c[k]) - DIFF_W'(e_c[k]);
            l_reg[k]  <= DIFF_W'(e_c[k]) - DIFF_W'(s_c[k]);
        end
    end

    // Stage two: all 33 by 33 products.
    always_ff @(posedge clk)
    begin
        dp_reg[0] <= l_reg[2] * r1_reg[1];
        dp_reg[1] <= l_reg[1] * r1_reg[2];
        dp_reg[2] <= l_reg[0] * r1_reg[2];
        dp_reg[3] <= l_reg[2] * r1_reg[0];
        dp_reg[4] <= l_reg[1] * r1_reg[0];
        dp_reg[5] <= l_reg[0] * r1_reg[1];
        for (int k = 0; k < 3; k++)
        begin
            sq1_reg[k] <= r1_reg[k] * r1_reg[k];
            sq2_reg[k] <= r2_reg[k] * r2_reg[k];
            lp1_reg[k] <= l_reg[k] * r1_reg[k];
            lp2_reg[k] <= l_reg[k] * r2_reg[k];
        end
    end

    // Stage three: sums, cross product and the degenerate-case status.
    always_comb
    begin
        out_next.dx  = CROSS_W'(dp_reg[0]) - CROSS_W'(dp_reg[1]);
        out_next.dy  = CROSS_W'(dp_reg[2]) - CROSS_W'(dp_reg[3]);
        out_next.dz  = CROSS_W'(dp_reg[4]) - CROSS_W'(dp_reg[5]);
        out_next.a   = SQ_W'(sq1_reg[0]) + SQ_W'(sq1_reg[1]) + SQ_W'(sq1_reg[2]);
        out_next.rr2 = SQ_W'(sq2_reg[0]) + SQ_W'(sq2_reg[1]) + SQ_W'(sq2_reg[2]);
        out_next.lr1 = DOT_W'(lp1_reg[0]) + DOT_W'(lp1_reg[1]) + DOT_W'(lp1_reg[2]);
        out_next.lr2 = DOT_W'(lp2_reg[0]) + DOT_W'(lp2_reg[1]) + DOT_W'(lp2_reg[2]);
        if (out_next.dx == '0 && out_next.dy == '0 && out_next.dz == '0)
        begin
            out_next.status = ST_DEN_ZERO;
        end
        else if (out_next.a == '0)
        begin
            out_next.status = ST_AT_START;
        end
        else
        begin
            out_next.status = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

### rtl/fvsv_sqrt.sv
// Pipelined integer square root of a squared length scaled by 2^64, one root bit per stage.
module fvsv_sqrt (
    input  logic                           clk,
    input  logic [fvsv_pkg::SQ_W-1:0]      radicand,
    output logic [fvsv_pkg::ROOT_W-1:0]    root
);
    import fvsv_pkg::*;

    logic [SQ_W-1:0]     rad_reg [ROOT_W];
    logic [ROOT_W+1:0]   rem_reg [ROOT_W];
    logic [ROOT_W-1:0]   q_reg   [ROOT_W];

    logic [SQ_W-1:0]     rad_in  [ROOT_W];
    logic [ROOT_W+1:0]   rem_in  [ROOT_W];
    logic [ROOT_W-1:0]   q_in    [ROOT_W];

    logic [SQ_W-1:0]     rad_next [ROOT_W];
    logic [ROOT_W+1:0]   rem_next [ROOT_W];
    logic [ROOT_W-1:0]   q_next   [ROOT_W];
    logic [ROOT_W+3:0]   rem_sh   [ROOT_W];
    logic [ROOT_W+3:0]   trial    [ROOT_W];
    logic [ROOT_W+3:0]   diff     [ROOT_W];

    // Each stage takes the previous stage's registers; the first takes the input.
    always_comb
    begin
        rad_in[0] = radicand;
        rem_in[0] = '0;
        q_in[0]   = '0;
        for (int i = 1; i < ROOT_W; i++)
        begin
            rad_in[i] = rad_reg[i-1];
            rem_in[i] = rem_reg[i-1];
            q_in[i]   = q_reg[i-1];
        end
    end

    // Restoring step: bring down two bits, try (4q + 1), keep one root bit.
    always_comb
    begin
        for (int i = 0; i < ROOT_W; i++)
        begin
            rem_sh[i] = {rem_in[i], rad_in[i][SQ_W-1:SQ_W-2]};
            trial[i]  = {2'b00, q_in[i], 2'b01};
            diff[i]   = rem_sh[i] - trial[i];
            if (rem_sh[i] >= trial[i])
            begin
                rem_next[i] = diff[i][ROOT_W+1:0];
                q_next[i]   = {q_in[i][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = rem_sh[i][ROOT_W+1:0];
                q_next[i]   = {q_in[i][ROOT_W-2:0], 1'b0};
            end
            rad_next[i] = {rad_in[i][SQ_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ROOT_W; i++)
        begin
            rad_reg[i] <= rad_next[i];
            rem_reg[i] <= rem_next[i];
            q_reg[i]   <= q_next[i];
        end
    end

    assign root = q_reg[ROOT_W-1];

endmodule

### rtl/fvsv_udiv.sv
// Pipelined rounded division u = l.r * 2^64 / |r|, one quotient bit per stage.
module fvsv_udiv (
    input  logic                                 clk,
    input  logic signed [fvsv_pkg::DOT_W-1:0]    num,
    input  logic [fvsv_pkg::ROOT_W-1:0]          root,
    output logic signed [fvsv_pkg::UNIT_W-1:0]   u
);
    import fvsv_pkg::*;

    logic [DOT_W-1:0]    mag_c;
    logic [UD_NUM_W-1:0] nsum_c;

    logic [UD_REM_W-1:0] rem_reg [UD_STEPS+1];
    logic [UD_REM_W-1:0] lo_reg  [UD_STEPS+1];
    logic [UD_DIV_W-1:0] dv_reg  [UD_STEPS+1];
    logic                neg_reg [UD_STEPS+1];

    logic [UD_REM_W:0]   rem_sh  [UD_STEPS+1];
    logic [UD_REM_W:0]   diff    [UD_STEPS+1];
    logic                ge      [UD_STEPS+1];

    logic signed [UNIT_W-1:0] u_reg;

    // Rounding numerator 2|n|*2^64 + s over divisor 2s.
    always_comb
    begin
        mag_c  = num[DOT_W-1] ? (DOT_W'(0) - num) : num;
        nsum_c = UD_NUM_W'({mag_c[DOT_W-2:0], 65'd0}) + UD_NUM_W'(root);
    end

    // Prepare stage.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= nsum_c[UD_NUM_W-1:UD_STEPS];
        lo_reg[0]  <= nsum_c[UD_STEPS-1:0];
        dv_reg[0]  <= {root, 1'b0};
        neg_reg[0] <= num[DOT_W-1];
    end

    // Restoring step, quotient bits shift in where numerator bits leave.
    always_comb
    begin
        rem_sh[0] = '0;
        diff[0]   = '0;
        ge[0]     = 1'b0;
        for (int k = 1; k <= UD_STEPS; k++)
        begin
            rem_sh[k] = {rem_reg[k-1], lo_reg[k-1][UD_STEPS-1]};
            diff[k]   = rem_sh[k] - (UD_REM_W+1)'(dv_reg[k-1]);
            ge[k]     = rem_sh[k] >= (UD_REM_W+1)'(dv_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= UD_STEPS; k++)
        begin
            rem_reg[k] <= ge[k] ? diff[k][UD_REM_W-1:0] : rem_sh[k][UD_REM_W-1:0];
            lo_reg[k]  <= {lo_reg[k-1][UD_STEPS-2:0], ge[k]};
            dv_reg[k]  <= dv_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
        end
    end

    // Output stage applies the sign.
    always_ff @(posedge clk)
    begin
        if (neg_reg[UD_STEPS])
        begin
            u_reg <= UNIT_W'(0) - UNIT_W'(lo_reg[UD_STEPS]);
        end
        else
        begin
            u_reg <= UNIT_W'(lo_reg[UD_STEPS]);
        end
    end

    assign u = u_reg;

endmodule

### rtl/fvsv_mul.sv
// Two-stage 68 by 68 unsigned multiplier built from four 34 by 34 partial products.
module fvsv_mul (
    input  logic                          clk,
    input  logic [fvsv_pkg::MUL_W-1:0]    a,
    input  logic [fvsv_pkg::MUL_W-1:0]    b,
    output logic [fvsv_pkg::MULP_W-1:0]   p
);
    import fvsv_pkg::*;

    logic [MUL_W-1:0]  hh_reg, hl_reg, lh_reg, ll_reg;
    logic [MULP_W-1:0] p_reg;

    // Partial products.
    always_ff @(posedge clk)
    begin
        hh_reg <= a[MUL_W-1:MUL_H] * b[MUL_W-1:MUL_H];
        hl_reg <= a[MUL_W-1:MUL_H] * b[MUL_H-1:0];
        lh_reg <= a[MUL_H-1:0] * b[MUL_W-1:MUL_H];
        ll_reg <= a[MUL_H-1:0] * b[MUL_H-1:0];
    end

    // Aligned sum.
    always_ff @(posedge clk)
    begin
        p_reg <= (MULP_W'(hh_reg) << (2 * MUL_H))
               + (MULP_W'(hl_reg) << MUL_H)
               + (MULP_W'(lh_reg) << MUL_H)
               + MULP_W'(ll_reg);
    end

    assign p = p_reg;

endmodule

### rtl/fvsv_vdiv.sv
// Pipelined rounded division d_k*U / d.d with Q16.16 saturation, one quotient bit per stage.
module fvsv_vdiv (
    input  logic                                clk,
    input  logic [fvsv_pkg::MULP_W-1:0]         mag,
    input  logic [fvsv_pkg::MULP_W-1:0]         den,
    input  logic                                neg,
    output logic signed [fvsv_pkg::COORD_W-1:0] vel,
    output logic                                sat
);
    import fvsv_pkg::*;

    logic [VD_NUM_W-1:0] num_reg;
    logic [VD_NUM_W-1:0] dv0_reg;
    logic                neg0_reg;

    logic [VD_NUM_W-1:0] rem_reg [VD_STEPS+1];
    logic [VD_STEPS-1:0] lo_reg  [VD_STEPS+1];
    logic [VD_NUM_W-1:0] dv_reg  [VD_STEPS+1];
    logic                neg_reg [VD_STEPS+1];
    logic                ovf_reg [VD_STEPS+1];

    logic [VD_NUM_W:0]   rem_sh  [VD_STEPS+1];
    logic [VD_NUM_W:0]   diff    [VD_STEPS+1];
    logic                ge      [VD_STEPS+1];

    logic [VD_STEPS-1:0]      q_c;
    logic signed [COORD_W-1:0] vel_reg;
    logic                      sat_reg;

    // Prepare: numerator 2|n| + den over divisor 2 den.
    always_ff @(posedge clk)
    begin
        num_reg  <= {mag, 1'b0} + VD_NUM_W'(den);
        dv0_reg  <= {den, 1'b0};
        neg0_reg <= neg;
    end

    // Quotient of 2^32 or more saturates whatever the sign.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= VD_NUM_W'(num_reg[VD_NUM_W-1:VD_STEPS]);
        lo_reg[0]  <= num_reg[VD_STEPS-1:0];
        dv_reg[0]  <= dv0_reg;
        neg_reg[0] <= neg0_reg;
        ovf_reg[0] <= VD_NUM_W'(num_reg[VD_NUM_W-1:VD_STEPS]) >= dv0_reg;
    end

    // Restoring steps.
    always_comb
    begin
        rem_sh[0] = '0;
        diff[0]   = '0;
        ge[0]     = 1'b0;
        for (int k = 1; k <= VD_STEPS; k++)
        begin
            rem_sh[k] = {rem_reg[k-1], lo_reg[k-1][VD_STEPS-1]};
            diff[k]   = rem_sh[k] - (VD_NUM_W+1)'(dv_reg[k-1]);
            ge[k]     = rem_sh[k] >= (VD_NUM_W+1)'(dv_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= VD_STEPS; k++)
        begin
            rem_reg[k] <= ge[k] ? diff[k][VD_NUM_W-1:0] : rem_sh[k][VD_NUM_W-1:0];
            lo_reg[k]  <= {lo_reg[k-1][VD_STEPS-2:0], ge[k]};
            dv_reg[k]  <= dv_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
        end
    end

    assign q_c = lo_reg[VD_STEPS];

    // Output stage: sign and clamp to the Q16.16 range.
    always_ff @(posedge clk)
    begin
        if (neg_reg[VD_STEPS])
        begin
            if (ovf_reg[VD_STEPS] || q_c > VEL_MIN)
            begin
                vel_reg <= VEL_MIN;
                sat_reg <= 1'b1;
            end
            else
            begin
                vel_reg <= COORD_W'(0) - q_c;
                sat_reg <= 1'b0;
            end
        end
        else
        begin
            if (ovf_reg[VD_STEPS] || q_c > VEL_MAX)
            begin
                vel_reg <= VEL_MAX;
                sat_reg <= 1'b1;
            end
            else
            begin
                vel_reg <= q_c;
                sat_reg <= 1'b0;
            end
        end
    end

    assign vel = vel_reg;
    assign sat = sat_reg;

endmodule

### rtl/finite_vortex_segment_velocity.sv
// Velocity induced by a unit-strength straight vortex segment at a target point.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the bit-per-stage square root (65) and the two divisions (67 and 32).
// Reset clears only the valid bits; no result is produced for requests in flight.
module finite_vortex_segment_velocity (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [fvsv_pkg::COORD_W-1:0] start_x,
    input  logic signed [fvsv_pkg::COORD_W-1:0] start_y,
    input  logic signed [fvsv_pkg::COORD_W-1:0] start_z,
    input  logic signed [fvsv_pkg::COORD_W-1:0] end_x,
    input  logic signed [fvsv_pkg::COORD_W-1:0] end_y,
    input  logic signed [fvsv_pkg::COORD_W-1:0] end_z,
    input  logic signed [fvsv_pkg::COORD_W-1:0] target_x,
    input  logic signed [fvsv_pkg::COORD_W-1:0] target_y,
    input  logic signed [fvsv_pkg::COORD_W-1:0] target_z,
    output logic                                done,
    output logic signed [fvsv_pkg::COORD_W-1:0] vel_x,
    output logic signed [fvsv_pkg::COORD_W-1:0] vel_y,
    output logic signed [fvsv_pkg::COORD_W-1:0] vel_z,
    output logic [1:0]                          status,
    output logic                                saturated
);
    import fvsv_pkg::*;

    logic   fr_valid;
    front_t fr;

    logic [ROOT_W-1:0]        s1, s2;
    logic [DOT_W-1:0]         lr1_dly_reg [LR_DLY];
    logic [DOT_W-1:0]         lr2_dly_reg [LR_DLY];
    logic signed [UNIT_W-1:0] u1, u2;

    logic signed [DIFFU_W-1:0] du_reg;
    logic [MUL_W-1:0]          um_reg;
    logic                      un_reg;

    logic [CROSS_W-1:0] d_c   [3];
    logic [CROSS_W-1:0] dabs_c[3];
    smag_t              d_dly_reg [D_DLY][3];

    logic [MULP_W-1:0] prod_c [3];
    logic [MULP_W-1:0] sq_c   [3];
    logic              vn1_reg [3];
    logic              vn2_reg [3];
    logic              vn3_reg [3];
    logic [MULP_W-1:0] pm_reg  [3];
    logic [MULP_W-1:0] den_reg;

    logic signed [COORD_W-1:0] v_c   [3];
    logic                      sat_c [3];

    logic    vld_dly_reg [ST_DLY];
    status_t st_dly_reg  [ST_DLY];

    logic                      done_reg;
    logic signed [COORD_W-1:0] velx_reg, vely_reg, velz_reg;
    status_t                   status_reg;
    logic                      sat_reg;

    assign busy = 1'b0;

    // Differences, products and sums.
    fvsv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .start_x  (start_x),
        .start_y  (start_y),
        .start_z  (start_z),
        .end_x    (end_x),
        .end_y    (end_y),
        .end_z    (end_z),
        .target_x (target_x),
        .target_y (target_y),
        .target_z (target_z),
        .out_valid(fr_valid),
        .out_data (fr)
    );

    // Lengths |r1| and |r2| with 32 fraction bits.
    fvsv_sqrt u_sqrt1 (.clk(clk), .radicand(fr.a),   .root(s1));
    fvsv_sqrt u_sqrt2 (.clk(clk), .radicand(fr.rr2), .root(s2));

    // Dot products wait for the square roots.
    always_ff @(posedge clk)
    begin
        lr1_dly_reg[0] <= fr.lr1;
        lr2_dly_reg[0] <= fr.lr2;
        for (int j = 1; j < LR_DLY; j++)
        begin
            lr1_dly_reg[j] <= lr1_dly_reg[j-1];
            lr2_dly_reg[j] <= lr2_dly_reg[j-1];
        end
    end

    // Projections u_i = l.r_i / |r_i|.
    fvsv_udiv u_udiv1 (.clk(clk), .num(lr1_dly_reg[LR_DLY-1]), .root(s1), .u(u1));
    fvsv_udiv u_udiv2 (.clk(clk), .num(lr2_dly_reg[LR_DLY-1]), .root(s2), .u(u2));

    // U = u2 - u1, then split into sign and magnitude.
    always_ff @(posedge clk)
    begin
        du_reg <= DIFFU_W'(u2) - DIFFU_W'(u1);
        un_reg <= du_reg[DIFFU_W-1];
        if (du_reg[DIFFU_W-1])
        begin
            um_reg <= MUL_W'(DIFFU_W'(0) - du_reg);
        end
        else
        begin
            um_reg <= MUL_W'(du_reg);
        end
    end

    // Cross product in sign and magnitude form, delayed to meet U.
    always_comb
    begin
        d_c[0] = fr.dx;
        d_c[1] = fr.dy;
        d_c[2] = fr.dz;
        for (int k = 0; k < 3; k++)
        begin
            dabs_c[k] = d_c[k][CROSS_W-1] ? (CROSS_W'(0) - d_c[k]) : d_c[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_dly_reg[0][k].mag <= dabs_c[k][MAG_W-1:0];
            d_dly_reg[0][k].neg <= d_c[k][CROSS_W-1];
            for (int j = 1; j < D_DLY; j++)
            begin
                d_dly_reg[j][k] <= d_dly_reg[j-1][k];
            end
        end
    end

    // Numerators d_k*U and the squares that make d.d.
    for (genvar k = 0; k < 3; k++)
    begin : g_mul
        fvsv_mul u_mul_prod (
            .clk(clk),
            .a  (MUL_W'(d_dly_reg[D_DLY-1][k].mag)),
            .b  (um_reg),
            .p  (prod_c[k])
        );
        fvsv_mul u_mul_sq (
            .clk(clk),
            .a  (MUL_W'(d_dly_reg[D_DLY-1][k].mag)),
            .b  (MUL_W'(d_dly_reg[D_DLY-1][k].mag)),
            .p  (sq_c[k])
        );
    end

    // Result signs follow the products; d.d is summed here.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            vn1_reg[k] <= d_dly_reg[D_DLY-1][k].neg ^ un_reg;
            vn2_reg[k] <= vn1_reg[k];
            vn3_reg[k] <= vn2_reg[k];
            pm_reg[k]  <= prod_c[k];
        end
        den_reg <= sq_c[0] + sq_c[1] + sq_c[2];
    end

    // Final rounded divisions with saturation.
    for (genvar k = 0; k < 3; k++)
    begin : g_vdiv
        fvsv_vdiv u_vdiv (
            .clk(clk),
            .mag(pm_reg[k]),
            .den(den_reg),
            .neg(vn3_reg[k]),
            .vel(v_c[k]),
            .sat(sat_c[k])
        );
    end

    // Valid bits and status ride alongside the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < ST_DLY; j++)
            begin
                vld_dly_reg[j] <= 1'b0;
            end
        end
        else
        begin
            vld_dly_reg[0] <= fr_valid;
            for (int j = 1; j < ST_DLY; j++)
            begin
                vld_dly_reg[j] <= vld_dly_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_dly_reg[0] <= fr.status;
        for (int j = 1; j < ST_DLY; j++)
        begin
            st_dly_reg[j] <= st_dly_reg[j-1];
        end
    end

    // Output register: degenerate cases give zero velocity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_dly_reg[ST_DLY-1];
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= st_dly_reg[ST_DLY-1];
        if (st_dly_reg[ST_DLY-1] == ST_OK)
        begin
            velx_reg <= v_c[0];
            vely_reg <= v_c[1];
            velz_reg <= v_c[2];
            sat_reg  <= sat_c[0] | sat_c[1] | sat_c[2];
        end
        else
        begin
            velx_reg <= '0;
            vely_reg <= '0;
            velz_reg <= '0;
            sat_reg  <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign vel_x     = velx_reg;
    assign vel_y     = vely_reg;
    assign vel_z     = velz_reg;
    assign status    = status_reg;
    assign saturated = sat_reg;

    // Every request gives exactly one result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##178 done)
        else $error("request did not produce a result at the expected cycle");

    // Degenerate geometry reports zero velocity and no clipping.
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |->
            vel_x == '0 && vel_y == '0 && vel_z == '0 && !saturated)
        else $error("nonzero velocity reported with an error status");

    // A sum of squares cannot be negative.
    a_no_neg_rad: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != ST_NEG_RAD)
        else $error("negative radicand status reported");

    // A clipped result leaves at least one component at a range limit.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |->
            vel_x == VEL_MAX || vel_x == VEL_MIN || vel_y == VEL_MAX ||
            vel_y == VEL_MIN || vel_z == VEL_MAX || vel_z == VEL_MIN)
        else $error("saturation flagged without a clipped component");

endmodule
